@@ hdl/swst_pkg.sv @@
package swst_pkg;

   localparam int WINDOW_MAX     = 64;
   localparam int SAMPLE_BITS    = 24;
   localparam int FRACTION_BITS  = 3;

   localparam int SEQ_BITS       = 32;
   localparam int VAL_BITS       = 28;
   localparam int WIN_BITS       = 7;
   localparam int SLOT_BITS      = 6;
   localparam int MINDEV_BITS    = 20;
   localparam int DUP_BITS       = 4;
   localparam int STATUS_BITS    = 3;
   localparam int OP_BITS        = 2;
   localparam int BIT_CNT_BITS   = $clog2(SEQ_BITS);

   // estimator gains and multipliers
   localparam int EST_SHIFT      = 3;   // gain 1/8
   localparam int DEV_SHIFT      = 2;   // gain 1/4
   localparam int RTO_DEV_SHIFT  = 2;   // rto = est + 4*dev
   localparam int DUP_FAST_RETX  = 3;

   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 20;

   localparam int REQ_TDATA_BITS = 56;
   localparam int REQ_TUSER_BITS = 2;
   localparam int RSP_TDATA_BITS = 104;
   localparam int RSP_TUSER_BITS = 4;

   typedef logic [SEQ_BITS-1:0]    seq_type;
   typedef logic [VAL_BITS-1:0]    val_type;
   typedef logic [WIN_BITS-1:0]    win_type;
   typedef logic [SLOT_BITS-1:0]   slot_type;
   typedef logic [DUP_BITS-1:0]    dup_type;

   typedef enum logic [OP_BITS-1:0] {
      OP_RESERVE,
      OP_TRANSMIT,
      OP_ACK,
      OP_HANDSHAKE
   } op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK,
      ST_WINDOW_FULL,
      ST_NOTHING_QUEUED,
      ST_ACK_OUTSIDE,
      ST_ACK_STALE
   } status_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_WINDOW_SIZE,
      CSR_MIN_DEVIATION
   } csr_index_type;

   // microseconds to fixed point, saturated to VAL_BITS
   function automatic val_type to_fixed(input seq_type us);
      logic [SEQ_BITS+FRACTION_BITS-1:0] wide;
      wide = {{FRACTION_BITS{1'b0}}, us} << FRACTION_BITS;
      if (wide[SEQ_BITS+FRACTION_BITS-1:VAL_BITS] != '0) begin
         return '1;
      end
      return wide[VAL_BITS-1:0];
   endfunction

endpackage

@@ hdl/sliding_window_sender_tracker_top.sv @@
// Sender-side sliding window tracker with a smoothed RTT / deviation timeout
// estimator. One request per clock while no slot recompute runs and the
// response side keeps up: a request is captured in the input register and
// its response is loaded into the output register. Buffer slots are
// tracked incrementally for the base, next-to-send and next-sequence
// counters. Each write of window_size starts a bit-serial remainder pass
// over the sequence bits that recomputes those slots; no request is
// accepted while it runs, and csr writes are always taken.
module sliding_window_sender_tracker_top (
   input  logic                                    clock,
   input  logic                                    reset,
   // request stream
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   // [31:0] ack_seq, [55:32] rtt_sample_us
   input  logic [swst_pkg::REQ_TDATA_BITS-1:0]     req_tdata,
   // [1:0] op
   input  logic [swst_pkg::REQ_TUSER_BITS-1:0]     req_tuser,
   // response stream
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   // [31:0] seq_out, [37:32] slot_out, [69:38] base_out, [73:70] dup_count,
   // [101:74] timeout_value, [103:102] zero
   output logic [swst_pkg::RSP_TDATA_BITS-1:0]     rsp_tdata,
   // [2:0] status, [3] fast_retransmit
   output logic [swst_pkg::RSP_TUSER_BITS-1:0]     rsp_tuser,
   // configuration writes
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [swst_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [swst_pkg::CSR_DATA_BITS-1:0]      csr_data
);
   import swst_pkg::*;

   localparam int EST_SUM_BITS = VAL_BITS + EST_SHIFT + 1;
   localparam int DEV_SUM_BITS = VAL_BITS + DEV_SHIFT;
   localparam int RTO_SUM_BITS = VAL_BITS + RTO_DEV_SHIFT + 1;
   localparam int HS_SUM_BITS  = VAL_BITS + 2;
   localparam int ACK_SUM_BITS = SLOT_BITS + 2;

   // configuration
   win_type                 window_ff;
   logic [MINDEV_BITS-1:0]  min_dev_ff;

   // slot recompute
   logic                    busy_ff;
   logic [BIT_CNT_BITS-1:0] bit_cnt_ff;
   logic                    csr_start;

   // input register
   logic                    in_valid_ff;
   op_type                  in_op_ff;
   seq_type                 in_ack_ff;
   logic [SAMPLE_BITS-1:0]  in_sample_ff;

   // state
   seq_type  base_ff, base_in;
   seq_type  nts_ff, nts_in;
   seq_type  nseq_ff, nseq_in;
   dup_type  dup_ff, dup_in;
   val_type  est_ff, est_in;
   val_type  dev_ff, dev_in;
   val_type  rto_ff, rto_in;
   slot_type slot_base_ff, slot_base_in;
   slot_type slot_nts_ff, slot_nts_in;
   slot_type slot_nseq_ff, slot_nseq_in;

   // response register
   logic       rsp_valid_ff;
   status_type rsp_status_ff, status_in;
   logic       rsp_fr_ff, fr_in;
   seq_type    rsp_seq_ff, seq_in;
   slot_type   rsp_slot_ff, slot_in;
   seq_type    rsp_base_ff;
   dup_type    rsp_dup_ff;
   val_type    rsp_rto_ff;

   logic    fire;
   win_type win;
   seq_type dist_seq, dist_nts, dist_ack;

   // estimator datapath
   val_type                  s_fix, m_fix, e_new, diff, d_new, dev_use;
   logic [EST_SUM_BITS-1:0]  est_sum;
   logic [DEV_SUM_BITS-1:0]  dev_sum;
   logic [RTO_SUM_BITS-1:0]  rto_sum;
   logic [HS_SUM_BITS-1:0]   hs_sum;
   val_type                  rto_ack, rto_hs;
   logic [ACK_SUM_BITS-1:0]  ack_sum;
   slot_type                 slot_ack;

   function automatic slot_type slot_next(input slot_type s, input win_type w);
      if ({1'b0, s} == SLOT_BITS'(w - WIN_BITS'(1)) + (SLOT_BITS + 1)'(0)) begin
         return '0;
      end
      return s + SLOT_BITS'(1);
   endfunction

   // one step of a restoring remainder, MSB first; r < w on entry
   function automatic slot_type rem_step(input slot_type r, input logic b,
                                         input win_type w);
      logic [SLOT_BITS:0] t;
      logic [SLOT_BITS:0] wx;
      t  = {r, b};
      wx = (SLOT_BITS + 1)'(w);
      if (t >= wx) begin
         t = t - wx;
      end
      return t[SLOT_BITS-1:0];
   endfunction

   assign csr_ready  = 1'b1;
   assign csr_start  = csr_valid && (csr_index == CSR_WINDOW_SIZE);
   assign fire       = in_valid_ff && !busy_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !busy_ff && (!in_valid_ff || fire);

   always_comb begin
      if (window_ff == '0) begin
         win = WIN_BITS'(1);
      end else if (window_ff > WIN_BITS'(WINDOW_MAX)) begin
         win = WIN_BITS'(WINDOW_MAX);
      end else begin
         win = window_ff;
      end
   end

   assign dist_seq = nseq_ff - base_ff;
   assign dist_nts = nts_ff - base_ff;
   assign dist_ack = in_ack_ff - base_ff;

   // estimator: est = (7*est + S) >> 3, dev = (3*dev + |S - new est|) >> 2
   assign s_fix   = to_fixed(SEQ_BITS'(in_sample_ff));
   assign m_fix   = to_fixed(SEQ_BITS'(min_dev_ff));
   assign est_sum = (EST_SUM_BITS'(est_ff) << EST_SHIFT) - EST_SUM_BITS'(est_ff)
                    + EST_SUM_BITS'(s_fix);
   assign e_new   = est_sum[VAL_BITS+EST_SHIFT-1:EST_SHIFT];
   assign diff    = (s_fix >= e_new) ? (s_fix - e_new) : (e_new - s_fix);
   assign dev_sum = (DEV_SUM_BITS'(dev_ff) << 1) + DEV_SUM_BITS'(dev_ff)
                    + DEV_SUM_BITS'(diff);
   assign d_new   = dev_sum[VAL_BITS+DEV_SHIFT-1:DEV_SHIFT];
   assign dev_use = (d_new > m_fix) ? d_new : m_fix;
   assign rto_sum = RTO_SUM_BITS'(e_new) + (RTO_SUM_BITS'(dev_use) << RTO_DEV_SHIFT);
   assign rto_ack = (rto_sum[RTO_SUM_BITS-1:VAL_BITS] != '0) ? '1
                                                           : rto_sum[VAL_BITS-1:0];
   assign hs_sum  = (HS_SUM_BITS'(s_fix) << 1) + HS_SUM_BITS'(s_fix);
   assign rto_hs  = (hs_sum[HS_SUM_BITS-1:VAL_BITS] != '0) ? '1
                                                         : hs_sum[VAL_BITS-1:0];

   // slot of the acked sequence: base slot plus a distance of at most one window
   assign ack_sum  = ACK_SUM_BITS'(slot_base_ff) + ACK_SUM_BITS'(dist_ack[WIN_BITS-1:0]);
   assign slot_ack = (ack_sum >= ACK_SUM_BITS'(win))
                     ? SLOT_BITS'(ack_sum - ACK_SUM_BITS'(win))
                     : ack_sum[SLOT_BITS-1:0];

   always_comb begin
      base_in      = base_ff;
      nts_in       = nts_ff;
      nseq_in      = nseq_ff;
      dup_in       = dup_ff;
      est_in       = est_ff;
      dev_in       = dev_ff;
      rto_in       = rto_ff;
      slot_base_in = slot_base_ff;
      slot_nts_in  = slot_nts_ff;
      slot_nseq_in = slot_nseq_ff;
      status_in    = ST_OK;
      fr_in        = 1'b0;
      seq_in       = '0;
      slot_in      = '0;

      if (busy_ff) begin
         slot_base_in = rem_step(slot_base_ff, base_ff[bit_cnt_ff], win);
         slot_nts_in  = rem_step(slot_nts_ff, nts_ff[bit_cnt_ff], win);
         slot_nseq_in = rem_step(slot_nseq_ff, nseq_ff[bit_cnt_ff], win);
      end else if (fire) begin
         case (in_op_ff)
            OP_RESERVE: begin
               if (dist_seq >= SEQ_BITS'(win)) begin
                  status_in = ST_WINDOW_FULL;
               end else begin
                  seq_in       = nseq_ff;
                  slot_in      = slot_nseq_ff;
                  nseq_in      = nseq_ff + SEQ_BITS'(1);
                  slot_nseq_in = slot_next(slot_nseq_ff, win);
               end
            end
            OP_TRANSMIT: begin
               if (nts_ff == nseq_ff) begin
                  status_in = ST_NOTHING_QUEUED;
               end else begin
                  seq_in      = nts_ff;
                  slot_in     = slot_nts_ff;
                  nts_in      = nts_ff + SEQ_BITS'(1);
                  slot_nts_in = slot_next(slot_nts_ff, win);
               end
            end
            OP_ACK: begin
               est_in = e_new;
               dev_in = d_new;
               rto_in = rto_ack;
               if (dist_ack == '0) begin
                  if (dup_ff != '1) begin
                     dup_in = dup_ff + DUP_BITS'(1);
                  end
                  fr_in = (dup_ff == DUP_BITS'(DUP_FAST_RETX - 1));
               end else if (dist_ack <= SEQ_BITS'(win)) begin
                  // counters passed by the ack are pulled up to the new base
                  if (dist_ack > dist_seq) begin
                     nseq_in      = in_ack_ff;
                     slot_nseq_in = slot_ack;
                  end
                  if (dist_ack > dist_nts) begin
                     nts_in      = in_ack_ff;
                     slot_nts_in = slot_ack;
                  end
                  base_in      = in_ack_ff;
                  slot_base_in = slot_ack;
                  dup_in       = '0;
               end else if (dist_ack[SEQ_BITS-1]) begin
                  status_in = ST_ACK_STALE;
               end else begin
                  status_in = ST_ACK_OUTSIDE;
               end
            end
            OP_HANDSHAKE: begin
               est_in = s_fix;
               dev_in = '0;
               rto_in = rto_hs;
            end
            default: begin
               status_in = ST_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= WIN_BITS'(16);
         min_dev_ff   <= MINDEV_BITS'(10000);
         busy_ff      <= 1'b0;
         bit_cnt_ff   <= '0;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         base_ff      <= '0;
         nts_ff       <= '0;
         nseq_ff      <= '0;
         dup_ff       <= '0;
         est_ff       <= '0;
         dev_ff       <= '0;
         rto_ff       <= '0;
         slot_base_ff <= '0;
         slot_nts_ff  <= '0;
         slot_nseq_ff <= '0;
      end else begin
         if (csr_valid) begin
            if (csr_index == CSR_WINDOW_SIZE) begin
               window_ff <= csr_data[WIN_BITS-1:0];
            end else begin
               min_dev_ff <= csr_data[MINDEV_BITS-1:0];
            end
         end

         if (csr_start) begin
            busy_ff    <= 1'b1;
            bit_cnt_ff <= BIT_CNT_BITS'(SEQ_BITS - 1);
         end else if (busy_ff) begin
            if (bit_cnt_ff == '0) begin
               busy_ff <= 1'b0;
            end else begin
               bit_cnt_ff <= bit_cnt_ff - BIT_CNT_BITS'(1);
            end
         end

         if (req_tvalid && req_tready) begin
            in_valid_ff <= 1'b1;
         end else if (fire) begin
            in_valid_ff <= 1'b0;
         end

         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         base_ff <= base_in;
         nts_ff  <= nts_in;
         nseq_ff <= nseq_in;
         dup_ff  <= dup_in;
         est_ff  <= est_in;
         dev_ff  <= dev_in;
         rto_ff  <= rto_in;

         if (csr_start) begin
            slot_base_ff <= '0;
            slot_nts_ff  <= '0;
            slot_nseq_ff <= '0;
         end else begin
            slot_base_ff <= slot_base_in;
            slot_nts_ff  <= slot_nts_in;
            slot_nseq_ff <= slot_nseq_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_op_ff     <= op_type'(req_tuser[OP_BITS-1:0]);
         in_ack_ff    <= req_tdata[SEQ_BITS-1:0];
         in_sample_ff <= req_tdata[SEQ_BITS+SAMPLE_BITS-1:SEQ_BITS];
      end
      if (fire) begin
         rsp_status_ff <= status_in;
         rsp_fr_ff     <= fr_in;
         rsp_seq_ff    <= seq_in;
         rsp_slot_ff   <= slot_in;
         rsp_base_ff   <= base_in;
         rsp_dup_ff    <= dup_in;
         rsp_rto_ff    <= rto_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = {rsp_fr_ff, rsp_status_ff};
   assign rsp_tdata  = RSP_TDATA_BITS'({rsp_rto_ff, rsp_dup_ff, rsp_base_ff,
                                        rsp_slot_ff, rsp_seq_ff});

endmodule
